/* rtl/pcs_pkg.sv */
// Shared widths, register indexes and sideband bit positions for the PID step block.
// Used by the top level pid_controller_step; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int ELAPSED_WIDTH   = 16;
  localparam int GAIN_WIDTH      = 16;
  localparam int ERR_WIDTH       = DATA_WIDTH + 1;
  localparam int DIFF_WIDTH      = DATA_WIDTH + 2;
  localparam int DRIVE_WIDTH     = 32;
  localparam int SUM_WIDTH       = 63;
  localparam int TERM_LIMIT_LOG2 = 60;
  localparam int CFG_INDEX_WIDTH = 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROP_GAIN  = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INTEG_GAIN = 8'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DERIV_GAIN = 8'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SETPOINT   = 8'd3;

  localparam int USER_SAT_BIT  = 0;
  localparam int USER_ZERO_BIT = 1;

  localparam logic signed [GAIN_WIDTH-1:0] GAIN_RESET     = 16'sd256;
  localparam logic signed [DATA_WIDTH-1:0] SETPOINT_RESET = 16'sd0;

endpackage

`default_nettype wire

/* rtl/pid_controller_step.sv */
// Top level of the PID step block: configuration registers, sequencer, integral and
// output saturation. Depends on pcs_pkg, pcs_sermul and pcs_serdiv.
`timescale 1ns / 1ps
`default_nettype none

// Each transferred sample (measurement, elapsed ticks) yields one drive value. A sample is
// taken only in the idle state, so the block is through with one sample before it takes the
// next: the error is formed, the first units are started, and the bit-serial derivative
// division runs alongside the proportional and integral-step products; their results are
// handed over and the integral is updated; the second units are started and form the integral
// and derivative gain products one gain bit per cycle; their results are handed over; then
// come the term clamp, the sum, the output saturation and the idle state. The result sits in an
// output register, so the next sample is taken while it waits to be read; a result that is
// still unread when the following one is ready holds the sequence until it is taken. Gains
// are signed Q8.8; an elapsed time of zero forces the derivative to zero, keeps the integral
// and sets zero_elapsed. Configuration must only be written while no sample is in flight.
module pid_controller_step
  import pcs_pkg::*;
#(
  parameter int FRAC_BITS      = 8,
  parameter int INTEGRAL_WIDTH = 48
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // s_tdata: [15:0] measurement, [31:16] elapsed
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [31:0]                s_tdata,
  // m_tdata: [31:0] drive
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [31:0]                     m_tdata,
  // m_tuser: [0] saturated, [1] zero_elapsed
  output logic [1:0]                      m_tuser,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [15:0]                cfg_data
);

  localparam int PROD_WIDTH  = ERR_WIDTH + ELAPSED_WIDTH + 1;
  localparam int PTERM_WIDTH = ERR_WIDTH + GAIN_WIDTH;
  localparam int DTERM_WIDTH = DIFF_WIDTH + GAIN_WIDTH;
  localparam int ITERM_WIDTH = INTEGRAL_WIDTH + GAIN_WIDTH;
  localparam int ISUM_WIDTH  = ((INTEGRAL_WIDTH > PROD_WIDTH) ? INTEGRAL_WIDTH : PROD_WIDTH) + 1;
  localparam int CMP_WIDTH   = (ITERM_WIDTH > SUM_WIDTH) ? ITERM_WIDTH : SUM_WIDTH;

  localparam logic signed [INTEGRAL_WIDTH-1:0] INTEG_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
  localparam logic signed [INTEGRAL_WIDTH-1:0] INTEG_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
  localparam logic signed [CMP_WIDTH-1:0] TERM_MAX =
    {{(CMP_WIDTH-TERM_LIMIT_LOG2){1'b0}}, {TERM_LIMIT_LOG2{1'b0}}} |
    (CMP_WIDTH'(1) << TERM_LIMIT_LOG2);
  localparam logic signed [CMP_WIDTH-1:0] TERM_MIN = -TERM_MAX;
  localparam logic signed [SUM_WIDTH-1:0] DRIVE_MAX =
    {{(SUM_WIDTH-DRIVE_WIDTH+1){1'b0}}, {(DRIVE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] DRIVE_MIN =
    {{(SUM_WIDTH-DRIVE_WIDTH+1){1'b1}}, {(DRIVE_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_START1,
    S_WAIT1,
    S_INTEG,
    S_START2,
    S_WAIT2,
    S_CLAMP,
    S_SUM,
    S_OUT
  } state_t;

  state_t state;

  logic signed [GAIN_WIDTH-1:0]     prop_gain;
  logic signed [GAIN_WIDTH-1:0]     integ_gain;
  logic signed [GAIN_WIDTH-1:0]     deriv_gain;
  logic signed [DATA_WIDTH-1:0]     setpoint;

  logic signed [DATA_WIDTH-1:0]     meas_r;
  logic [ELAPSED_WIDTH-1:0]         elapsed_r;
  logic signed [ERR_WIDTH-1:0]      err_r;
  logic signed [ERR_WIDTH-1:0]      last_error;
  logic signed [DIFF_WIDTH-1:0]     diff_r;
  logic signed [DIFF_WIDTH-1:0]     deriv_r;
  logic signed [INTEGRAL_WIDTH-1:0] integral;
  logic                             zero_r;
  logic                             sat_int;
  logic signed [SUM_WIDTH-1:0]      term_i;
  logic signed [SUM_WIDTH-1:0]      pd_sum;
  logic signed [SUM_WIDTH-1:0]      sum_r;

  logic signed [ERR_WIDTH-1:0]      err_next;
  logic signed [DIFF_WIDTH-1:0]     diff_next;
  logic signed [ISUM_WIDTH-1:0]     isum;
  logic signed [INTEGRAL_WIDTH-1:0] integral_next;
  logic                             integ_clip;
  logic signed [CMP_WIDTH-1:0]      iterm_x;
  logic signed [SUM_WIDTH-1:0]      term_i_next;
  logic signed [SUM_WIDTH-1:0]      drv_shift;
  logic signed [DRIVE_WIDTH-1:0]    drive_next;
  logic                             drive_clip;

  logic                             start1;
  logic                             start2;
  logic                             prod_busy;
  logic                             pterm_busy;
  logic                             div_busy;
  logic                             iterm_busy;
  logic                             dterm_busy;
  logic signed [PROD_WIDTH-1:0]     prod;
  logic signed [PTERM_WIDTH-1:0]    pterm;
  logic signed [ITERM_WIDTH-1:0]    iterm;
  logic signed [DTERM_WIDTH-1:0]    dterm;
  logic signed [DIFF_WIDTH-1:0]     quot;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign start1    = (state == S_START1);
  assign start2    = (state == S_START2);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= GAIN_RESET;
      integ_gain <= GAIN_RESET;
      deriv_gain <= GAIN_RESET;
      setpoint   <= SETPOINT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain  <= cfg_data;
        REG_INTEG_GAIN: integ_gain <= cfg_data;
        REG_DERIV_GAIN: deriv_gain <= cfg_data;
        REG_SETPOINT:   setpoint   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Elapsed time enters the integral product as a non-negative signed operand.
  pcs_sermul #(.A_WIDTH(ERR_WIDTH), .B_WIDTH(ELAPSED_WIDTH + 1)) u_prod (
    .clk(clk), .rst(rst), .start(start1),
    .a(err_r), .b($signed({1'b0, elapsed_r})), .busy(prod_busy), .p(prod)
  );

  pcs_sermul #(.A_WIDTH(ERR_WIDTH), .B_WIDTH(GAIN_WIDTH)) u_pterm (
    .clk(clk), .rst(rst), .start(start1),
    .a(err_r), .b(prop_gain), .busy(pterm_busy), .p(pterm)
  );

  pcs_serdiv #(.N_WIDTH(DIFF_WIDTH), .D_WIDTH(ELAPSED_WIDTH)) u_div (
    .clk(clk), .rst(rst), .start(start1),
    .dividend(diff_r), .divisor(elapsed_r), .busy(div_busy), .quotient(quot)
  );

  pcs_sermul #(.A_WIDTH(INTEGRAL_WIDTH), .B_WIDTH(GAIN_WIDTH)) u_iterm (
    .clk(clk), .rst(rst), .start(start2),
    .a(integral), .b(integ_gain), .busy(iterm_busy), .p(iterm)
  );

  pcs_sermul #(.A_WIDTH(DIFF_WIDTH), .B_WIDTH(GAIN_WIDTH)) u_dterm (
    .clk(clk), .rst(rst), .start(start2),
    .a(deriv_r), .b(deriv_gain), .busy(dterm_busy), .p(dterm)
  );

  always_comb begin
    err_next  = ERR_WIDTH'(setpoint) - ERR_WIDTH'(meas_r);
    diff_next = DIFF_WIDTH'(err_next) - DIFF_WIDTH'(last_error);

    isum = ISUM_WIDTH'(integral) + ISUM_WIDTH'(prod);
    if (isum > ISUM_WIDTH'(INTEG_MAX)) begin
      integral_next = INTEG_MAX;
      integ_clip    = 1'b1;
    end else if (isum < ISUM_WIDTH'(INTEG_MIN)) begin
      integral_next = INTEG_MIN;
      integ_clip    = 1'b1;
    end else begin
      integral_next = INTEGRAL_WIDTH'(isum);
      integ_clip    = 1'b0;
    end

    // The integral term is limited to plus or minus two to the sixtieth before summing.
    iterm_x = CMP_WIDTH'(iterm);
    if (iterm_x > TERM_MAX) begin
      term_i_next = SUM_WIDTH'(TERM_MAX);
    end else if (iterm_x < TERM_MIN) begin
      term_i_next = SUM_WIDTH'(TERM_MIN);
    end else begin
      term_i_next = SUM_WIDTH'(iterm_x);
    end

    drv_shift = sum_r >>> FRAC_BITS;
    if (drv_shift > DRIVE_MAX) begin
      drive_next = DRIVE_WIDTH'(DRIVE_MAX);
      drive_clip = 1'b1;
    end else if (drv_shift < DRIVE_MIN) begin
      drive_next = DRIVE_WIDTH'(DRIVE_MIN);
      drive_clip = 1'b1;
    end else begin
      drive_next = DRIVE_WIDTH'(drv_shift);
      drive_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      integral   <= '0;
      last_error <= '0;
      sat_int    <= 1'b0;
    end else begin
      // In S_OUT the output register is refilled below instead.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            meas_r    <= s_tdata[DATA_WIDTH-1:0];
            elapsed_r <= s_tdata[16 +: ELAPSED_WIDTH];
            state     <= S_ERR;
          end
        end
        S_ERR: begin
          err_r  <= err_next;
          diff_r <= diff_next;
          zero_r <= (elapsed_r == '0);
          state  <= S_START1;
        end
        S_START1: begin
          state <= S_WAIT1;
        end
        S_WAIT1: begin
          if (!(prod_busy || pterm_busy || div_busy)) begin
            state <= S_INTEG;
          end
        end
        S_INTEG: begin
          if (!zero_r) begin
            integral <= integral_next;
            sat_int  <= integ_clip;
            deriv_r  <= quot;
          end else begin
            sat_int  <= 1'b0;
            deriv_r  <= '0;
          end
          last_error <= err_r;
          state      <= S_START2;
        end
        S_START2: begin
          state <= S_WAIT2;
        end
        S_WAIT2: begin
          if (!(iterm_busy || dterm_busy)) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          term_i <= term_i_next;
          pd_sum <= SUM_WIDTH'(pterm) + SUM_WIDTH'(dterm);
          state  <= S_SUM;
        end
        S_SUM: begin
          sum_r <= term_i + pd_sum;
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold here until the output register is free or being emptied by this transfer.
          if (!m_tvalid || m_tready) begin
            m_tvalid                <= 1'b1;
            m_tdata                 <= drive_next;
            m_tuser[USER_SAT_BIT]  <= sat_int || drive_clip;
            m_tuser[USER_ZERO_BIT] <= zero_r;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_ERR))
    else $error("sample transfer did not start the sequence");

  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(prod_busy || pterm_busy || div_busy || iterm_busy || dterm_busy))
    else $error("arithmetic unit busy while ready for a new sample");

  a_zero_keeps_integral: assert property (@(posedge clk) disable iff (rst)
    (state == S_INTEG && zero_r) |=> $stable(integral))
    else $error("integral changed on a zero elapsed time");

  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    sat_int |-> (integral == INTEG_MAX || integral == INTEG_MIN))
    else $error("integral clip flagged but integral not at a bound");

endmodule

`default_nettype wire

/* rtl/pcs_sermul.sv */
// Serial-parallel signed multiplier: the serial operand is consumed one bit per cycle.
// Standalone; instantiated by pid_controller_step.
`timescale 1ns / 1ps
`default_nettype none

module pcs_sermul #(
  parameter int A_WIDTH = 17,
  parameter int B_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [A_WIDTH-1:0]          a,
  input  wire logic signed [B_WIDTH-1:0]          b,
  output logic                                    busy,
  output logic signed [A_WIDTH+B_WIDTH-1:0]       p
);

  localparam int P_WIDTH = A_WIDTH + B_WIDTH;
  localparam int CNT_W   = $clog2(B_WIDTH + 1);

  logic signed [P_WIDTH-1:0] mcand;
  logic signed [P_WIDTH-1:0] acc;
  logic [B_WIDTH-1:0]        mplier;
  logic [CNT_W-1:0]          cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(B_WIDTH);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The top bit of the serial operand carries negative weight, so it is subtracted.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= P_WIDTH'(a);
      mplier <= b;
      acc    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        if (cnt == CNT_W'(1)) begin
          acc <= acc - mcand;
        end else begin
          acc <= acc + mcand;
        end
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign p = acc;

endmodule

`default_nettype wire

/* rtl/pcs_serdiv.sv */
// Restoring divider, one quotient bit per cycle: signed dividend over a nonzero unsigned
// divisor, quotient truncated toward zero. Standalone; instantiated by pid_controller_step.
`timescale 1ns / 1ps
`default_nettype none

module pcs_serdiv #(
  parameter int N_WIDTH = 18,
  parameter int D_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic signed [N_WIDTH-1:0] dividend,
  input  wire logic [D_WIDTH-1:0]        divisor,
  output logic                           busy,
  output logic signed [N_WIDTH-1:0]      quotient
);

  localparam int CNT_W = $clog2(N_WIDTH + 1);

  logic [N_WIDTH-1:0] qreg;
  logic [D_WIDTH-1:0] rem;
  logic [D_WIDTH-1:0] dsor;
  logic               neg;
  logic [CNT_W-1:0]   cnt;
  logic [D_WIDTH:0]   trial;
  logic               fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(N_WIDTH);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    trial = {rem, qreg[N_WIDTH-1]};
    fits  = (trial >= {1'b0, dsor});
  end

  // Dividend magnitude bits leave the top of qreg as quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      qreg <= dividend[N_WIDTH-1] ? N_WIDTH'(-dividend) : N_WIDTH'(dividend);
      neg  <= dividend[N_WIDTH-1];
      rem  <= '0;
      dsor <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= D_WIDTH'(trial - {1'b0, dsor});
      end else begin
        rem <= trial[D_WIDTH-1:0];
      end
      qreg <= {qreg[N_WIDTH-2:0], fits};
    end
  end

  assign quotient = neg ? -$signed(qreg) : $signed(qreg);

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for pid_controller_step: streams samples in, checks every drive result
// against a cycle-free predictor of the PID step. Depends on pcs_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
  import pcs_pkg::*;

  localparam int     FRAC_BITS      = 8;
  localparam int     INTEGRAL_WIDTH = 48;
  localparam longint INTEG_MAX      = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint INTEG_MIN      = -INTEG_MAX - 1;
  localparam longint TERM_CAP       = longint'(1) <<< TERM_LIMIT_LOG2;
  localparam longint PULL_BAND      = longint'(1) <<< 24;
  localparam int     SETTLE_CYCLES  = 60;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     REPORT_CAP     = 100;
  localparam int     RAND_PHASES    = 12;
  localparam int     PHASE_SAMPLES  = 112;
  localparam int     WIND_SAMPLES   = 16;

  // Indexes past the register file; writes to them must be dropped.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BEYOND_LO = 8'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BEYOND_HI = 8'hFF;

  typedef struct packed {
    logic signed [DRIVE_WIDTH-1:0] drive;
    logic                          clip;
    logic                          zero;
  } drive_result_t;

  logic                       clk;
  logic                       rst       = 1'b1;
  logic                       s_tvalid  = 1'b0;
  logic                       s_tready;
  logic [31:0]                s_tdata   = '0;   // [15:0] measurement, [31:16] elapsed
  logic                       m_tvalid;
  logic                       m_tready  = 1'b0;
  logic [31:0]                m_tdata;          // [31:0] drive
  logic [1:0]                 m_tuser;          // [0] saturated, [1] zero_elapsed
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [15:0]                cfg_data  = '0;

  // Predictor copy of the registers and the loop state.
  logic signed [GAIN_WIDTH-1:0] prop_gain_q  = GAIN_RESET;
  logic signed [GAIN_WIDTH-1:0] integ_gain_q = GAIN_RESET;
  logic signed [GAIN_WIDTH-1:0] deriv_gain_q = GAIN_RESET;
  logic signed [DATA_WIDTH-1:0] setpoint_q   = SETPOINT_RESET;
  logic signed [INTEGRAL_WIDTH-1:0] integ_acc = '0;
  logic signed [ERR_WIDTH-1:0]      last_err  = '0;

  logic [31:0]   sample_q[$];
  drive_result_t drive_q[$];
  drive_result_t want;

  bit       sender_idle_en    = 1'b1;
  bit       receiver_stall_en = 1'b1;
  int       gap_left          = 0;
  int       burst_left        = 1;
  logic [15:0] rx_pat         = '1;
  logic [3:0]  rx_pos         = '0;
  int       quiet             = 0;
  int       fails             = 0;
  int       n_samples         = 0;
  int       n_results         = 0;
  int       n_clip            = 0;
  int       n_zero            = 0;
  int       n_writes          = 0;

  pid_controller_step #(
    .FRAC_BITS      (FRAC_BITS),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One PID step: updates the integral and the stored error, returns the expected result.
  function automatic drive_result_t pid_predict(input logic [31:0] sample);
    longint        meas, dt, err, prod, acc, deriv, mag, lim, term, sum, drv;
    drive_result_t r;
    meas   = longint'($signed(sample[15:0]));
    dt     = longint'(sample[31:16]);
    err    = longint'(setpoint_q) - meas;
    acc    = longint'(integ_acc);
    deriv  = 0;
    r.clip = 1'b0;
    r.zero = (dt == 0);
    if (!r.zero) begin
      prod = err * dt;
      if (prod > 0 && acc > INTEG_MAX - prod) begin
        acc    = INTEG_MAX;
        r.clip = 1'b1;
      end else if (prod < 0 && acc < INTEG_MIN - prod) begin
        acc    = INTEG_MIN;
        r.clip = 1'b1;
      end else begin
        acc += prod;
      end
      deriv = (err - longint'(last_err)) / dt;
    end
    // The integral term is capped at a magnitude of 2^60 before the sum.
    mag = integ_gain_q < 0 ? -longint'(integ_gain_q) : longint'(integ_gain_q);
    if (mag == 0) begin
      term = 0;
    end else begin
      lim = TERM_CAP / mag;
      if (acc > lim) term = integ_gain_q > 0 ? TERM_CAP : -TERM_CAP;
      else if (acc < -lim) term = integ_gain_q > 0 ? -TERM_CAP : TERM_CAP;
      else term = longint'(integ_gain_q) * acc;
    end
    sum = longint'(prop_gain_q) * err + term + longint'(deriv_gain_q) * deriv;
    drv = sum >>> FRAC_BITS;
    if (drv > longint'(32'sh7FFF_FFFF)) begin
      drv    = longint'(32'sh7FFF_FFFF);
      r.clip = 1'b1;
    end else if (drv < -longint'(32'sh7FFF_FFFF) - 1) begin
      drv    = -longint'(32'sh7FFF_FFFF) - 1;
      r.clip = 1'b1;
    end
    r.drive   = drv[31:0];
    integ_acc = acc[INTEGRAL_WIDTH-1:0];
    last_err  = err[ERR_WIDTH-1:0];
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps, unless idling is disabled.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        drive_q.push_back(pid_predict(s_tdata));
        n_samples++;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s_tdata  <= sample_q.pop_front();
          s_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 7))
              0, 1:    gap_left = 0;
              2, 3, 4: gap_left = $urandom_range(1, 20);
              5, 6:    gap_left = $urandom_range(21, 60);
              default: gap_left = $urandom_range(61, 120);
            endcase
            if (!sender_idle_en) gap_left = 0;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and, when stalling is enabled, stalls on a slowly changing bit pattern.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_CAP)
            $error("drive result with no sample pending: drive %0d", $signed(m_tdata));
        end else begin
          want = drive_q.pop_front();
          n_results++;
          n_clip += want.clip;
          n_zero += want.zero;
          if (m_tdata !== want.drive) begin
            fails++;
            if (fails <= REPORT_CAP)
              $error("drive: expected %0d, actual %0d", want.drive, $signed(m_tdata));
          end
          if (m_tuser[USER_SAT_BIT] !== want.clip) begin
            fails++;
            if (fails <= REPORT_CAP)
              $error("saturated: expected %0b, actual %0b", want.clip, m_tuser[USER_SAT_BIT]);
          end
          if (m_tuser[USER_ZERO_BIT] !== want.zero) begin
            fails++;
            if (fails <= REPORT_CAP)
              $error("zero_elapsed: expected %0b, actual %0b", want.zero,
                     m_tuser[USER_ZERO_BIT]);
          end
        end
      end
      if (rx_pos == 0 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0:       rx_pat = '1;
          1:       rx_pat = 16'($urandom);
          2:       rx_pat = 16'($urandom & $urandom);
          default: rx_pat = 16'($urandom | $urandom);
        endcase
      end
      m_tready <= !receiver_stall_en || rx_pat[rx_pos];
      rx_pos++;
    end
  end

  // Ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes++;
    case (idx)
      REG_PROP_GAIN:  prop_gain_q  = val;
      REG_INTEG_GAIN: integ_gain_q = val;
      REG_DERIV_GAIN: deriv_gain_q = val;
      REG_SETPOINT:   setpoint_q   = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] kp, ki, kd, sp);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_DERIV_GAIN, kd);
    write_reg(REG_SETPOINT, sp);
    @(negedge clk);
  endtask

  // Waits until every queued sample is sent and every expected result has come back, then lets the block settle.
  task automatic drain();
    do @(negedge clk); while (sample_q.size() != 0 || s_tvalid || drive_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Drives the integral back towards zero with a few large steps of the opposite sign,
  // so that later phases still produce drive values that are not clipped.
  task automatic pull_back();
    longint             acc, err, dt;
    logic signed [15:0] meas;
    int                 n;
    acc = longint'(integ_acc);
    n   = 0;
    while (n < 8 && (acc > PULL_BAND || acc < -PULL_BAND)) begin
      meas = acc > 0 ? 16'sh7FFF : 16'sh8000;
      err  = longint'(setpoint_q) - longint'(meas);
      if (err == 0) break;
      dt = (acc < 0 ? -acc : acc) / (err < 0 ? -err : err);
      if (dt > 65535) dt = 65535;
      if (dt < 1) dt = 1;
      sample_q.push_back({dt[15:0], meas});
      acc += err * dt;
      n++;
    end
    drain();
  endtask

  function automatic logic [15:0] rand_gain(input int span);
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  // Mostly samples that track the setpoint closely, the rest anywhere in range.
  function automatic logic [31:0] rand_sample();
    int          m;
    logic [15:0] e;
    case ($urandom_range(0, 9))
      0:       m = -32768;
      1:       m = 32767;
      2, 3:    m = $signed(16'($urandom));
      default: m = int'(setpoint_q) + $urandom_range(0, 1023) - 512;
    endcase
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    case ($urandom_range(0, 19))
      0, 1:            e = 16'd0;
      2:               e = 16'hFFFF;
      3, 4, 5, 6, 7,
      8, 9:            e = 16'($urandom_range(1, 15));
      10, 11, 12, 13:  e = 16'($urandom_range(16, 1023));
      default:         e = 16'($urandom);
    endcase
    return {e, m[15:0]};
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset register values, extremes of both fields and zero elapsed time.
    sample_q.push_back({16'd0,     16'sh0000});
    sample_q.push_back({16'd1,     16'sh7FFF});
    sample_q.push_back({16'd1,     16'sh8000});
    sample_q.push_back({16'hFFFF,  16'sh8000});
    sample_q.push_back({16'hFFFF,  16'sh7FFF});
    sample_q.push_back({16'd0,     16'sh0064});
    sample_q.push_back({16'd2,     16'shFFFF});
    sample_q.push_back({16'd3,     16'sh0001});
    sample_q.push_back({16'd7,     16'sh0000});
    drain();

    // Writes past the register file must leave the gains untouched.
    write_reg(REG_BEYOND_LO, 16'h1234);
    write_reg(REG_BEYOND_HI, 16'hFFFF);
    @(negedge clk);
    sample_q.push_back({16'd5,     16'sh0123});
    sample_q.push_back({16'd0,     16'shFEDC});
    drain();

    set_regs(16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
    sample_q.push_back({16'd1,     16'sh7FFF});
    sample_q.push_back({16'hFFFF,  16'sh8000});
    sample_q.push_back({16'd0,     16'sh7FFF});
    sample_q.push_back({16'd3,     16'sh0000});
    drain();

    set_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    sample_q.push_back({16'd1,     16'sh8000});
    sample_q.push_back({16'hFFFF,  16'sh7FFF});
    sample_q.push_back({16'd0,     16'sh8000});
    sample_q.push_back({16'd9,     16'sh1000});
    drain();

    set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    sample_q.push_back({16'hFFFF,  16'sh8000});
    sample_q.push_back({16'd1,     16'sh7FFF});
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      pull_back();
      if (ph == 0)
        set_regs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      else if (ph == 1)
        set_regs(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      else
        set_regs(rand_gain(1024), rand_gain(16), rand_gain(1024), rand_gain(32767));
      repeat (PHASE_SAMPLES) sample_q.push_back(rand_sample());
      drain();
    end

    // The largest positive step, back to back, with no idling on either side.
    pull_back();
    set_regs(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    sender_idle_en    = 1'b0;
    receiver_stall_en = 1'b0;
    repeat (WIND_SAMPLES) sample_q.push_back({16'hFFFF, 16'sh8000});
    drain();

    // Coming back down with negative error, and a zero elapsed time on a large integral.
    sender_idle_en    = 1'b1;
    receiver_stall_en = 1'b1;
    write_reg(REG_SETPOINT, 16'h8000);
    @(negedge clk);
    sample_q.push_back({16'd0,    16'sh7FFF});
    sample_q.push_back({16'd1000, 16'sh7FFF});
    sample_q.push_back({16'd1,    16'sh7FFF});
    drain();

    $display("Checked %0d drive results from %0d samples after %0d register writes.",
             n_results, n_samples, n_writes);
    $display("%0d results were clipped, %0d had zero elapsed time; %0d mismatches.",
             n_clip, n_zero, fails);
    if (fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
